>>> rtl/hnrl_pkg.sv
`default_nettype none
package hnrl_pkg;
   localparam int MaxEntries    = 2048;
   localparam int MaxFlagFrames = 144;
   localparam int NumBuckets    = 256;
   localparam int FlagChunks    = (MaxFlagFrames + 63) / 64;
   localparam int EntryBits     = $clog2(MaxEntries);
   localparam int PtrBits       = EntryBits + 1;
   localparam int ChunkBits     = (FlagChunks > 1) ? $clog2(FlagChunks) : 1;
   localparam int FlagAddrBits  = $clog2(MaxEntries * FlagChunks);
   localparam int FrameIdxBits  = (MaxFlagFrames > 1) ? $clog2(MaxFlagFrames) : 1;

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_FLAGS  = 2'd1;
   localparam logic [1:0] REQ_LOOKUP = 2'd2;
   localparam logic [1:0] REQ_RSVD   = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_RSVD = 2'd3;

   localparam logic [1:0] ADDR_DEF_FRAMES = 2'd0;
   localparam logic [1:0] ADDR_DEF_SPEED  = 2'd1;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [63:0] key_bytes;
      logic [7:0]  bucket;
      logic [15:0] frame_count;
      logic [15:0] anim_speed;
      logic [1:0]  chunk_index;
      logic [63:0] chunk_flags;
   } req_type_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] out_frames;
      logic [15:0] out_speed;
      logic [15:0] first_tagged;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request, fold key
      logic ins_head;   // read bucket head/tail for insert
      logic ins_write;  // write record and link
      logic flag_clear; // clear one flag chunk of new record
      logic flag_write;
      logic lk_head;    // read bucket head for lookup
      logic lk_read;    // issue entry read
      logic lk_cmp;     // compare entry, advance
      logic scan;       // scan one flag chunk
      logic miss;
      logic hit_done;
      logic plain_done;
      logic full_done;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] req;
      logic       full;
      logic       chain_end;
      logic       match;
      logic       scan_done;
      logic       clear_done;
   } sts_type;
endpackage
`default_nettype wire

>>> rtl/hashed_name_record_lookup_core.sv
`default_nettype none
// An insert reads the bucket head and tail, writes the record and link, then clears the
// new record's flag chunks one by one; a flag write completes at dispatch; a lookup
// reads and compares chain entries in turn and, on a hit, scans its flag chunks in order.
// One item at a time: the next is taken the cycle after the result loads, unless a
// stalled result still holds the output register. Reset (synchronous) empties all
// buckets, zeroes the entry count and loads the default registers; no clearing pass.
module hashed_name_record_lookup_core (
   input  wire  logic                   clock,
   input  wire  logic                   reset,
   input  wire  logic                   req_valid,
   output logic                         req_stall,
   input  wire  hnrl_pkg::req_type_type req_data,
   output logic                         rsp_valid,
   input  wire  logic                   rsp_stall,
   output hnrl_pkg::rsp_type            rsp_data,
   input  wire  logic                   psel,
   input  wire  logic                   penable,
   input  wire  logic                   pwrite,
   input  wire  logic [2:0]             paddr,
   input  wire  logic [31:0]            pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   hnrl_pkg::cmd_type cmd;
   hnrl_pkg::sts_type sts;
   logic              res_load;
   hnrl_pkg::rsp_type res_data;
   logic [15:0]       def_frames_ff, def_speed_ff;

   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         def_frames_ff <= 16'd2048;
         def_speed_ff  <= 16'd256;
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == 1'b0 && paddr[1:0] == 2'd0) def_frames_ff <= pwdata[15:0];
         else if (paddr[2] == 1'b1 && paddr[1:0] == 2'd0) def_speed_ff <= pwdata[15:0];
      end
   end
   always_comb begin
      prdata = '0;
      case ({1'b0, paddr[2]})
         hnrl_pkg::ADDR_DEF_FRAMES: prdata = {16'd0, def_frames_ff};
         hnrl_pkg::ADDR_DEF_SPEED:  prdata = {16'd0, def_speed_ff};
         default: prdata = '0;
      endcase
   end

   // the output register frees at the accepting edge unless its item is stalled
   hnrl_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .out_busy(rsp_valid && rsp_stall), .cmd(cmd), .sts(sts)
   );

   hnrl_datapath u_dp (
      .clock(clock), .reset(reset), .req_data(req_data), .cmd(cmd), .sts(sts),
      .def_frames(def_frames_ff), .def_speed(def_speed_ff),
      .res_load(res_load), .res_data(res_data)
   );

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (res_load) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
   end
   always_ff @(posedge clock) begin
      if (res_load) rsp_data <= res_data;
   end
endmodule
`default_nettype wire

>>> rtl/hnrl_ctrl.sv
`default_nettype none
module hnrl_ctrl (
   input  wire  logic              clock,
   input  wire  logic              reset,
   input  wire  logic              req_valid,
   output logic                    req_stall,
   input  wire  logic              out_busy,
   output hnrl_pkg::cmd_type       cmd,
   input  wire  hnrl_pkg::sts_type sts
);
   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_INS_HEAD, S_INS_WRITE, S_CLEAR, S_LK_HEAD, S_LK_READ,
      S_LK_CMP, S_SCAN, S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !out_busy) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (sts.req)
               hnrl_pkg::REQ_INSERT: begin
                  if (sts.full) begin
                     cmd.full_done = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     cmd.ins_head = 1'b1;
                     state_in = S_INS_HEAD;
                  end
               end
               hnrl_pkg::REQ_FLAGS: begin
                  cmd.flag_write = 1'b1;
                  cmd.plain_done = 1'b1;
                  state_in = S_IDLE;
               end
               hnrl_pkg::REQ_LOOKUP: begin
                  cmd.lk_head = 1'b1;
                  state_in = S_LK_HEAD;
               end
               default: begin
                  cmd.plain_done = 1'b1;
                  state_in = S_IDLE;
               end
            endcase
         end
         S_INS_HEAD: begin
            cmd.ins_write = 1'b1;
            state_in = S_CLEAR;
         end
         S_CLEAR: begin
            cmd.flag_clear = 1'b1;
            if (sts.clear_done) begin
               cmd.plain_done = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_LK_HEAD: begin
            if (sts.chain_end) begin
               cmd.miss = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.lk_read = 1'b1;
               state_in = S_LK_READ;
            end
         end
         S_LK_READ: state_in = S_LK_CMP;
         S_LK_CMP: begin
            cmd.lk_cmp = 1'b1;
            if (sts.match) state_in = S_SCAN;
            else state_in = S_LK_HEAD;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) state_in = S_DONE;
         end
         S_DONE: begin
            cmd.hit_done = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign req_stall = !(state_ff == S_IDLE && !out_busy);
endmodule
`default_nettype wire

>>> rtl/hnrl_datapath.sv
`default_nettype none
module hnrl_datapath (
   input  wire  logic                   clock,
   input  wire  logic                   reset,
   input  wire  hnrl_pkg::req_type_type req_data,
   input  wire  hnrl_pkg::cmd_type      cmd,
   output hnrl_pkg::sts_type            sts,
   input  wire  logic [15:0]            def_frames,
   input  wire  logic [15:0]            def_speed,
   output logic                         res_load,
   output hnrl_pkg::rsp_type            res_data
);
   localparam int EB = hnrl_pkg::EntryBits;
   localparam int PB = hnrl_pkg::PtrBits;
   localparam int CB = hnrl_pkg::ChunkBits;
   localparam int FB = hnrl_pkg::FlagAddrBits;
   localparam int FC = hnrl_pkg::FlagChunks;
   localparam logic [PB-1:0] NoEntry = PB'(hnrl_pkg::MaxEntries);

   // memories
   logic [PB-1:0] head_mem [hnrl_pkg::NumBuckets];
   logic [EB-1:0] tail_mem [hnrl_pkg::NumBuckets];
   logic [PB-1:0] next_mem [hnrl_pkg::MaxEntries];
   logic [63:0]   name_mem [hnrl_pkg::MaxEntries];
   logic [15:0]   frm_mem  [hnrl_pkg::MaxEntries];
   logic [15:0]   spd_mem  [hnrl_pkg::MaxEntries];
   logic [63:0]   flag_mem [hnrl_pkg::MaxEntries * FC];
   logic [hnrl_pkg::NumBuckets-1:0] head_vld_ff;

   hnrl_pkg::req_type_type r_ff;
   logic [63:0]   fold_ff;
   logic [7:0]    hash_ff;
   logic [PB-1:0] count_ff;
   logic [PB-1:0] cur_ff, steps_ff;
   logic          head_v_ff;
   logic [EB-1:0] tail_rd_ff;
   logic [PB-1:0] next_rd_ff;
   logic [63:0]   name_rd_ff, flag_rd_ff;
   logic [15:0]   frm_rd_ff, spd_rd_ff;
   logic [CB-1:0] chunk_ff;
   logic          flag_pend_ff, found_ff;
   logic [15:0]   ft_ff;

   logic [63:0]   fold_c;
   logic [7:0]    hash_c;
   logic          stop_c;
   logic [7:0]    ch_c;

   always_comb begin
      fold_c = req_data.key_bytes;
      hash_c = '0;
      stop_c = 1'b0;
      ch_c = '0;
      for (int b = 0; b < 8; b++) begin
         ch_c = req_data.key_bytes[b*8 +: 8];
         if (ch_c == 8'd0) stop_c = 1'b1;
         if (!stop_c) begin
            if (ch_c >= 8'h61 && ch_c <= 8'h7a) ch_c = ch_c - 8'h20;
            fold_c[b*8 +: 8] = ch_c;
            hash_c = hash_c + ch_c;
         end
      end
   end

   logic [EB-1:0] new_e;
   assign new_e = count_ff[EB-1:0];
   // newest record; the count has already advanced past it while its flags clear
   logic [PB-1:0] last_e;
   assign last_e = count_ff - 1'b1;
   logic [FB-1:0] clr_addr, last_addr, scan_addr;
   assign clr_addr  = FB'(last_e[EB-1:0]) * FB'(FC) + FB'(chunk_ff);
   assign last_addr = FB'(last_e) * FB'(FC) + FB'(r_ff.chunk_index);
   assign scan_addr = FB'(cur_ff[EB-1:0]) * FB'(FC) + FB'(chunk_ff);

   // flag scan of the chunk read last cycle
   logic          scan_hit;
   logic [15:0]   scan_idx;
   logic          scan_last;
   logic [16:0]   lim;
   always_comb begin
      lim = (frm_rd_ff < 16'(hnrl_pkg::MaxFlagFrames)) ? {1'b0, frm_rd_ff}
            : 17'(hnrl_pkg::MaxFlagFrames);
      scan_hit = 1'b0;
      scan_idx = '0;
      for (int i = 63; i >= 0; i--) begin
         if (flag_rd_ff[i] && (17'(chunk_ff) * 17'd64 + 17'(i)) < lim) begin
            scan_hit = 1'b1;
            scan_idx = 16'(17'(chunk_ff) * 17'd64 + 17'(i));
         end
      end
      scan_last = (17'(chunk_ff) * 17'd64 + 17'd64 >= lim);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         r_ff    <= req_data;
         fold_ff <= fold_c;
         hash_ff <= hash_c;
         steps_ff <= '0;
         chunk_ff <= '0;
         flag_pend_ff <= 1'b0;
         found_ff <= 1'b0;
      end
      if (cmd.ins_head) begin
         head_v_ff  <= head_vld_ff[r_ff.bucket];
         tail_rd_ff <= tail_mem[r_ff.bucket];
      end
      if (cmd.ins_write) begin
         name_mem[new_e] <= r_ff.key_bytes;
         frm_mem[new_e]  <= r_ff.frame_count;
         spd_mem[new_e]  <= r_ff.anim_speed;
         next_mem[new_e] <= NoEntry;
         tail_mem[r_ff.bucket] <= new_e;
         if (!head_v_ff) head_mem[r_ff.bucket] <= PB'(new_e);
         else next_mem[tail_rd_ff] <= PB'(new_e);
      end
      if (cmd.flag_clear) begin
         flag_mem[clr_addr] <= '0;
         chunk_ff <= chunk_ff + 1'b1;
      end
      if (cmd.flag_write && count_ff != '0 && r_ff.chunk_index < 2'(FC))
         flag_mem[last_addr] <= r_ff.chunk_flags;
      if (cmd.lk_head && !cmd.load) begin
         head_v_ff  <= head_vld_ff[hash_ff];
         cur_ff     <= head_mem[hash_ff];
      end
      if (cmd.lk_read) begin
         name_rd_ff <= name_mem[cur_ff[EB-1:0]];
         next_rd_ff <= next_mem[cur_ff[EB-1:0]];
         frm_rd_ff  <= frm_mem[cur_ff[EB-1:0]];
         spd_rd_ff  <= spd_mem[cur_ff[EB-1:0]];
      end
      if (cmd.lk_cmp) begin
         steps_ff <= steps_ff + 1'b1;
         if (!sts.match) cur_ff <= next_rd_ff;
         flag_pend_ff <= 1'b0;
         chunk_ff <= '0;
         ft_ff <= '0;
      end
      if (cmd.scan) begin
         if (!flag_pend_ff) begin
            flag_rd_ff   <= flag_mem[scan_addr];
            flag_pend_ff <= 1'b1;
         end else if (!found_ff) begin
            if (scan_hit) begin
               ft_ff <= scan_idx;
               found_ff <= 1'b1;
            end else if (scan_last) begin
               ft_ff <= (frm_rd_ff > 16'(hnrl_pkg::MaxFlagFrames))
                        ? 16'(hnrl_pkg::MaxFlagFrames) : 16'd0;
               found_ff <= 1'b1;
            end else begin
               chunk_ff <= chunk_ff + 1'b1;
               flag_pend_ff <= 1'b0;
            end
         end
      end
   end

   // lookup head: first lk_head cycle sees registered head; chain walk uses cur_ff
   logic walk_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= '0;
         count_ff <= '0;
         walk_ff <= 1'b0;
      end else begin
         if (cmd.ins_write) begin
            head_vld_ff[r_ff.bucket] <= 1'b1;
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.lk_head) walk_ff <= 1'b1;
         if (cmd.miss || cmd.load) walk_ff <= 1'b0;
      end
   end

   always_comb begin
      sts.req        = r_ff.req_type;
      sts.full       = (count_ff >= PB'(hnrl_pkg::MaxEntries));
      sts.chain_end  = walk_ff ? (!head_v_ff || cur_ff >= NoEntry || steps_ff >= count_ff)
                               : 1'b0;
      sts.match      = (name_rd_ff == fold_ff);
      sts.scan_done  = found_ff;
      sts.clear_done = (chunk_ff == CB'(FC - 1));
   end

   assign res_load = cmd.miss | cmd.hit_done | cmd.plain_done | cmd.full_done;
   always_comb begin
      res_data = '0;
      if (cmd.full_done) res_data.status = hnrl_pkg::ST_FULL;
      else if (cmd.miss) begin
         res_data.status = hnrl_pkg::ST_MISS;
         res_data.out_frames = def_frames;
         res_data.out_speed = def_speed;
         res_data.first_tagged = def_frames;
      end else if (cmd.hit_done) begin
         res_data.status = hnrl_pkg::ST_OK;
         res_data.out_frames = frm_rd_ff;
         res_data.out_speed = spd_rd_ff;
         res_data.first_tagged = ft_ff;
      end
   end
endmodule
`default_nettype wire

>>> rtl/hnrl_checker.sv
`default_nettype none
module hnrl_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire hnrl_pkg::rsp_type rsp_data
);
   a_no_accept_while_full: assert property (@(posedge clock) disable iff (reset)
      req_valid && rsp_valid && rsp_stall |-> req_stall)
      else $error("item accepted with result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status != hnrl_pkg::ST_RSVD) else $error("bad status");
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");
endmodule

bind hashed_name_record_lookup_core hnrl_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
`default_nettype wire

>>> tb/hashed_name_record_lookup_core_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module hashed_name_record_lookup_core_tb;
   localparam int CycleLimit = 3000000;
   localparam int MaxEntries = hnrl_pkg::MaxEntries;
   localparam int FlagChunks = hnrl_pkg::FlagChunks;
   localparam int MaxFlagFrames = hnrl_pkg::MaxFlagFrames;
   localparam int NumBuckets = hnrl_pkg::NumBuckets;
   localparam int NoEntry    = hnrl_pkg::MaxEntries;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   hnrl_pkg::req_type_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   hnrl_pkg::rsp_type rsp_data;
   logic psel, penable, pwrite;
   logic [2:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   hashed_name_record_lookup_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // table shadow
   logic [15:0] dflt_frames, dflt_speed;
   int          head_of [NumBuckets];
   int          tail_of [NumBuckets];
   int          next_of [MaxEntries];
   logic [63:0] name_of [MaxEntries];
   logic [15:0] frames_of [MaxEntries];
   logic [15:0] speed_of [MaxEntries];
   logic [63:0] flags_of [MaxEntries * FlagChunks];
   int          rec_count;

   hnrl_pkg::req_type_type pending_items[$];
   hnrl_pkg::rsp_type      expected_rsps[$];
   int           errors;
   int           cycles;
   bit           drain_mode;   // no idling near the end
   bit           hold_off;
   int           send_gap, recv_gap, hold_cnt;
   logic [63:0]  known_names[$];

   function automatic hnrl_pkg::rsp_type predict_table(hnrl_pkg::req_type_type it);
      hnrl_pkg::rsp_type r;
      logic [63:0] k;
      logic [7:0] h, c;
      int e, steps, lim, ft;
      bit hit, stop;
      r = '0;
      case (it.req_type)
         hnrl_pkg::REQ_INSERT: begin
            if (rec_count >= MaxEntries) begin
               r.status = hnrl_pkg::ST_FULL;
            end else begin
               e = rec_count;
               name_of[e] = it.key_bytes;
               frames_of[e] = it.frame_count;
               speed_of[e] = it.anim_speed;
               next_of[e] = NoEntry;
               for (int i = 0; i < FlagChunks; i++) flags_of[e * FlagChunks + i] = '0;
               if (head_of[it.bucket] == NoEntry) head_of[it.bucket] = e;
               else next_of[tail_of[it.bucket]] = e;
               tail_of[it.bucket] = e;
               rec_count = e + 1;
            end
         end
         hnrl_pkg::REQ_FLAGS: begin
            if (rec_count > 0 && it.chunk_index < FlagChunks)
               flags_of[(rec_count - 1) * FlagChunks + it.chunk_index] = it.chunk_flags;
         end
         hnrl_pkg::REQ_LOOKUP: begin
            k = it.key_bytes;
            h = '0;
            stop = 0;
            for (int b = 0; b < 8; b++) begin
               c = it.key_bytes[b*8 +: 8];
               if (c == 8'h00) stop = 1;
               if (!stop) begin
                  if (c >= 8'h61 && c <= 8'h7a) c = c - 8'h20;
                  k[b*8 +: 8] = c;
                  h = h + c;
               end
            end
            e = head_of[h];
            steps = 0;
            hit = 0;
            while (!hit && e < MaxEntries && steps < rec_count) begin
               if (name_of[e] == k) hit = 1;
               else begin
                  e = next_of[e];
                  steps++;
               end
            end
            if (hit) begin
               r.out_frames = frames_of[e];
               r.out_speed = speed_of[e];
               lim = frames_of[e] < MaxFlagFrames ? frames_of[e] : MaxFlagFrames;
               ft = -1;
               for (int i = 0; i < lim && ft < 0; i++)
                  if (flags_of[e * FlagChunks + i / 64][i % 64]) ft = i;
               if (ft < 0) ft = frames_of[e] > MaxFlagFrames ? MaxFlagFrames : 0;
               r.first_tagged = ft[15:0];
            end else begin
               r.status = hnrl_pkg::ST_MISS;
               r.out_frames = dflt_frames;
               r.out_speed = dflt_speed;
               r.first_tagged = dflt_frames;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
         send_gap <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(predict_table(req_data));
            void'(pending_items.pop_front());
         end
         if (req_valid && req_stall) begin
            // hold the stalled item
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 0;
         end else if (!drain_mode && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(0, 5);
            req_valid <= 0;
         end else if (pending_items.size() > 0) begin
            req_valid <= 1;
            req_data <= pending_items[0];
         end else begin
            req_valid <= 0;
         end
      end
   end

   // receiver stall and monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
         recv_gap <= 0;
         hold_cnt <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected result", '0, '0);
            end else begin
               hnrl_pkg::rsp_type w;
               w = expected_rsps.pop_front();
               if (rsp_data.status !== w.status)
                  report_mismatch("status", {14'd0, rsp_data.status}, {14'd0, w.status});
               if (rsp_data.out_frames !== w.out_frames)
                  report_mismatch("frames", rsp_data.out_frames, w.out_frames);
               if (rsp_data.out_speed !== w.out_speed)
                  report_mismatch("speed", rsp_data.out_speed, w.out_speed);
               if (rsp_data.first_tagged !== w.first_tagged)
                  report_mismatch("first_tagged", rsp_data.first_tagged, w.first_tagged);
            end
         end
         if (hold_off) begin
            rsp_stall <= 1;
            hold_cnt <= hold_cnt + 1;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_stall <= 1;
         end else if (!drain_mode && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(0, 5);
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] data);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx[0], 2'b00}; pwdata <= data;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      if (idx == hnrl_pkg::ADDR_DEF_FRAMES) dflt_frames = data[15:0];
      else dflt_speed = data[15:0];
      // read back the register just written
      @(posedge clock);
      if (prdata !== {16'd0, data[15:0]})
         report_mismatch("csr readback", prdata[15:0], data[15:0]);
   endtask

   task automatic wait_idle();
      while (pending_items.size() > 0 || expected_rsps.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [63:0] rand_name();
      logic [63:0] n;
      int len;
      n = '0;
      len = $urandom_range(1, 8);
      for (int b = 0; b < len; b++)
         n[b*8 +: 8] = ($urandom_range(0, 1)) ? 8'($urandom_range(8'h41, 8'h5a))
                                               : 8'($urandom_range(8'h61, 8'h7a));
      if ($urandom_range(0, 7) == 0) n[63:56] = 8'($urandom);  // tail byte after zero
      return n;
   endfunction

   function automatic logic [7:0] name_hash(logic [63:0] n);
      logic [7:0] h, c;
      h = 0;
      for (int b = 0; b < 8; b++) begin
         c = n[b*8 +: 8];
         if (c == 0) return h;
         if (c >= 8'h61 && c <= 8'h7a) c = c - 8'h20;
         h = h + c;
      end
      return h;
   endfunction

   function automatic logic [63:0] upper_name(logic [63:0] n);
      logic [63:0] u;
      u = n;
      for (int b = 0; b < 8; b++) begin
         if (n[b*8 +: 8] == 0) return u;
         if (n[b*8 +: 8] >= 8'h61 && n[b*8 +: 8] <= 8'h7a) u[b*8 +: 8] = n[b*8 +: 8] - 8'h20;
      end
      return u;
   endfunction

   task automatic add_item(logic [1:0] op, logic [63:0] key, logic [7:0] bkt,
                           logic [15:0] fr, logic [15:0] sp, logic [1:0] ci,
                           logic [63:0] fl);
      hnrl_pkg::req_type_type it;
      it.req_type = op; it.key_bytes = key; it.bucket = bkt; it.frame_count = fr;
      it.anim_speed = sp; it.chunk_index = ci; it.chunk_flags = fl;
      pending_items.push_back(it);
   endtask

   task automatic add_record();
      logic [63:0] n, stored;
      logic [15:0] fr;
      n = rand_name();
      stored = $urandom_range(0, 5) == 0 ? n : upper_name(n);
      fr = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 200));
      add_item(hnrl_pkg::REQ_INSERT, stored,
               $urandom_range(0, 9) == 0 ? 8'($urandom) : name_hash(n),
               fr, 16'($urandom), 2'($urandom), 64'($urandom));
      known_names.push_back(n);
      for (int c = 0; c < 3; c++) begin
         if ($urandom_range(0, 2) != 0) begin
            logic [63:0] f;
            f = {$urandom, $urandom};
            if ($urandom_range(0, 1)) f = f & {$urandom, $urandom} & {$urandom, $urandom};
            if ($urandom_range(0, 3) == 0) f = '0;
            add_item(hnrl_pkg::REQ_FLAGS, {$urandom, $urandom}, 8'($urandom),
                     16'($urandom), 16'($urandom), c[1:0], f);
         end
      end
   endtask

   task automatic add_lookup();
      logic [63:0] k;
      if (known_names.size() > 0 && $urandom_range(0, 3) != 0)
         k = known_names[$urandom_range(0, known_names.size() - 1)];
      else
         k = $urandom_range(0, 1) ? rand_name() : {$urandom, $urandom};
      add_item(hnrl_pkg::REQ_LOOKUP, k, 8'($urandom), 16'($urandom), 16'($urandom),
               2'($urandom), {$urandom, $urandom});
   endtask

   initial begin
      reset = 1;
      req_valid = 0; req_data = '0; rsp_stall = 0;
      psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
      errors = 0; cycles = 0; drain_mode = 0; hold_off = 0;
      send_gap = 0; recv_gap = 0; hold_cnt = 0;
      dflt_frames = 16'd2048; dflt_speed = 16'd256; rec_count = 0;
      for (int i = 0; i < NumBuckets; i++) begin
         head_of[i] = NoEntry;
         tail_of[i] = 0;
      end
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: flags and lookup on an empty table, odd request type
      add_item(hnrl_pkg::REQ_FLAGS, '0, '0, '0, '0, 2'd0, '1);
      add_item(hnrl_pkg::REQ_LOOKUP, "aaa", 8'd0, '0, '0, '0, '0);
      add_item(hnrl_pkg::REQ_LOOKUP, '0, 8'd0, '0, '0, '0, '0);
      add_item(hnrl_pkg::REQ_RSVD, '1, '1, '1, '1, '1, '1);
      add_item(hnrl_pkg::REQ_INSERT, 64'h0000_0000_0043_4241, 8'hc6, 16'hffff, 16'hffff,
               '0, '0);
      add_item(hnrl_pkg::REQ_FLAGS, '0, '0, '0, '0, 2'd3, '1);
      add_item(hnrl_pkg::REQ_FLAGS, '0, '0, '0, '0, 2'd2, 64'h8000_0000_0000_0000);
      add_item(hnrl_pkg::REQ_LOOKUP, 64'h0000_0000_0063_6261, 8'h0, '0, '0, '0, '0);
      add_item(hnrl_pkg::REQ_FLAGS, '0, '0, '0, '0, 2'd2, 64'h0000_0000_0000_8000);
      add_item(hnrl_pkg::REQ_LOOKUP, 64'h0000_0000_0043_4261, 8'h0, '0, '0, '0, '0);
      add_item(hnrl_pkg::REQ_FLAGS, '0, '0, '0, '0, 2'd0, 64'h0000_0000_0000_0001);
      add_item(hnrl_pkg::REQ_LOOKUP, 64'h0000_0000_0043_4241, 8'h0, '0, '0, '0, '0);
      // lower-case stored name never matches a lookup
      add_item(hnrl_pkg::REQ_INSERT, 64'h0000_0000_0000_6161, 8'h82, 16'd0, 16'd0, '0, '0);
      add_item(hnrl_pkg::REQ_LOOKUP, 64'h0000_0000_0000_6161, 8'h0, '0, '0, '0, '0);
      // bytes after the zero still compared
      add_item(hnrl_pkg::REQ_INSERT, 64'hff00_0000_0000_0041, 8'h41, 16'd5, 16'd7, '0, '0);
      add_item(hnrl_pkg::REQ_LOOKUP, 64'hff00_0000_0000_0061, 8'h0, '0, '0, '0, '0);
      add_item(hnrl_pkg::REQ_LOOKUP, 64'h0000_0000_0000_0041, 8'h0, '0, '0, '0, '0);
      add_item(hnrl_pkg::REQ_INSERT, '1, 8'hf8, 16'd144, 16'd0, '0, '0);
      add_item(hnrl_pkg::REQ_LOOKUP, '1, 8'h0, '0, '0, '0, '0);
      wait_idle();
      csr_write(hnrl_pkg::ADDR_DEF_FRAMES, 32'h0000_ffff);
      csr_write(hnrl_pkg::ADDR_DEF_SPEED, 32'h0000_0000);
      add_item(hnrl_pkg::REQ_LOOKUP, 64'h1234, 8'h0, '0, '0, '0, '0);

      // long receiver hold-off while items keep coming
      for (int i = 0; i < 20; i++) add_lookup();
      hold_off = 1;
      while (hold_cnt < 300) @(posedge clock);
      hold_off = 0;
      wait_idle();

      for (int ph = 0; ph < 4; ph++) begin
         csr_write(hnrl_pkg::ADDR_DEF_FRAMES, ph == 0 ? 32'h0 : $urandom);
         csr_write(hnrl_pkg::ADDR_DEF_SPEED, ph == 0 ? 32'hffff : $urandom);
         if (ph == 3) drain_mode = 1;
         while (pending_items.size() < 400) begin
            if ($urandom_range(0, 2) == 0) add_record();
            else add_lookup();
            if ($urandom_range(0, 19) == 0)
               add_item(2'($urandom), {$urandom, $urandom}, 8'($urandom), 16'($urandom),
                        16'($urandom), 2'($urandom), {$urandom, $urandom});
         end
         wait_idle();
      end

      // fill the table to overflow
      drain_mode = 0;
      while (rec_count + pending_items.size() < MaxEntries + 40) begin
         add_item(hnrl_pkg::REQ_INSERT, {$urandom, $urandom}, 8'($urandom), 16'($urandom),
                  16'($urandom), '0, '0);
         if (pending_items.size() > 200) @(posedge clock);
      end
      drain_mode = 1;
      for (int i = 0; i < 30; i++) add_lookup();
      add_item(hnrl_pkg::REQ_FLAGS, '0, '0, '0, '0, 2'd1, '1);
      add_lookup();
      wait_idle();

      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
`default_nettype wire
